// ===== src/mau_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix arithmetic unit package
// Transfer types, operation and register codes, and the microcode program
// of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mau_pkg;

    localparam int CNT_W     = 3;
    localparam int DIM_W     = 4;
    localparam int REG_IDX_W = 3;
    localparam int STEP_W    = 4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [CNT_W-1:0]   col;
        logic [CNT_W-1:0]   row;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0]   out_col;
        logic [CNT_W-1:0]   out_row;
        logic signed [31:0] out_value;
        logic               last;
        logic               error;
    } t_out_item;

    localparam logic [1:0] OPC_WRITE_A = 2'd0;
    localparam logic [1:0] OPC_WRITE_B = 2'd1;
    localparam logic [1:0] OPC_COMPUTE = 2'd2;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_SUB   = 2'd1;
    localparam logic [1:0] MODE_MUL   = 2'd2;
    localparam logic [1:0] MODE_SCALE = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_OP_MODE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_A_COLS  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_A_ROWS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_B_COLS  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_B_ROWS  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SCALE   = 3'd5;

    typedef enum logic [1:0] {RD_NONE, RD_ELEM, RD_MAC} t_rd;
    typedef enum logic [1:0] {WT_NONE, WT_MUL, WT_OUT} t_wt;
    typedef enum logic [1:0] {ALU_NONE, ALU_ELEM, ALU_MAC, ALU_CLR} t_alu;
    typedef enum logic [1:0] {EM_NONE, EM_DATA, EM_ERR} t_emit;
    typedef enum logic [2:0] {
        J_NEXT, J_ALW, J_NOGO, J_ERR, J_MUL, J_IMORE, J_YMORE, J_XMORE
    } t_jmp;

    typedef struct packed {
        t_rd               rd;
        t_wt               wt;
        t_alu              alu;
        t_emit             emit;
        logic              mstart;
        logic              clr_cnt;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_uword;

    localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] ST_CHECK    = 4'd1;
    localparam logic [STEP_W-1:0] ST_DISPATCH = 4'd2;
    localparam logic [STEP_W-1:0] ST_EREAD    = 4'd3;
    localparam logic [STEP_W-1:0] ST_ESTART   = 4'd4;
    localparam logic [STEP_W-1:0] ST_ERES     = 4'd5;
    localparam logic [STEP_W-1:0] ST_MREAD    = 4'd6;
    localparam logic [STEP_W-1:0] ST_MSTART   = 4'd7;
    localparam logic [STEP_W-1:0] ST_MACC     = 4'd8;
    localparam logic [STEP_W-1:0] ST_EMIT     = 4'd9;
    localparam logic [STEP_W-1:0] ST_NEXTX    = 4'd10;
    localparam logic [STEP_W-1:0] ST_DONE     = 4'd11;
    localparam logic [STEP_W-1:0] ST_ERR      = 4'd12;

    function automatic t_uword uc_rom(input logic [STEP_W-1:0] s);
        t_uword w;
        w = '{rd: RD_NONE, wt: WT_NONE, alu: ALU_NONE, emit: EM_NONE,
              mstart: 1'b0, clr_cnt: 1'b0, jmp: J_NEXT, target: ST_IDLE};
        case (s)
            ST_IDLE: begin
                w.clr_cnt = 1'b1;
                w.alu     = ALU_CLR;
                w.jmp     = J_NOGO;
                w.target  = ST_IDLE;
            end
            ST_CHECK: begin
                w.jmp    = J_ERR;
                w.target = ST_ERR;
            end
            ST_DISPATCH: begin
                w.jmp    = J_MUL;
                w.target = ST_MREAD;
            end
            ST_EREAD: begin
                w.rd = RD_ELEM;
            end
            ST_ESTART: begin
                w.mstart = 1'b1;
            end
            ST_ERES: begin
                w.wt     = WT_MUL;
                w.alu    = ALU_ELEM;
                w.jmp    = J_ALW;
                w.target = ST_EMIT;
            end
            ST_MREAD: begin
                w.rd = RD_MAC;
            end
            ST_MSTART: begin
                w.mstart = 1'b1;
            end
            ST_MACC: begin
                w.wt     = WT_MUL;
                w.alu    = ALU_MAC;
                w.jmp    = J_IMORE;
                w.target = ST_MREAD;
            end
            ST_EMIT: begin
                w.wt     = WT_OUT;
                w.emit   = EM_DATA;
                w.alu    = ALU_CLR;
                w.jmp    = J_YMORE;
                w.target = ST_DISPATCH;
            end
            ST_NEXTX: begin
                w.jmp    = J_XMORE;
                w.target = ST_DISPATCH;
            end
            ST_DONE: begin
                w.jmp    = J_ALW;
                w.target = ST_IDLE;
            end
            ST_ERR: begin
                w.wt     = WT_OUT;
                w.emit   = EM_ERR;
                w.jmp    = J_ALW;
                w.target = ST_IDLE;
            end
            default: begin
                w.jmp    = J_ALW;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/mau_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/mau_qmul.sv =====
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Iterative Q16.16 product: magnitudes are multiplied chunk by chunk, then
// shifted right by 16 with rounding toward minus infinity and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module mau_qmul #(
    parameter int EB = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [EB-1:0] i_a,
    input  wire logic signed [EB-1:0] i_b,
    output logic                      o_busy,
    output logic signed [EB-1:0]      o_q
);

    localparam int NCH = (EB + 31) / 32;
    localparam int CW  = (EB + NCH - 1) / NCH;
    localparam int MW  = NCH * CW;
    localparam int AW2 = 2 * MW + 1;
    localparam int CIW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int SHW = (NCH > 1) ? $clog2(2 * NCH - 1) : 1;

    localparam logic [EB-1:0] EMAX = {1'b0, {(EB-1){1'b1}}};
    localparam logic [EB-1:0] EMIN = {1'b1, {(EB-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ADD  = 4'b0100,
        S_FIN  = 4'b1000
    } t_mstate;

    t_mstate              r_st;
    logic [MW-1:0]        r_x;
    logic [MW-1:0]        r_y;
    logic                 r_neg;
    logic [CIW-1:0]       r_ci;
    logic [CIW-1:0]       r_cj;
    logic [2*CW-1:0]      r_pp;
    logic [SHW-1:0]       r_sh;
    logic [AW2-1:0]       r_mag;
    logic signed [EB-1:0] r_q;

    logic [EB-1:0]  a_mag;
    logic [EB-1:0]  b_mag;
    logic [AW2-1:0] rnd;
    logic [AW2-1:0] shq;
    logic           ovf;
    logic [EB-1:0]  fin_q;
    logic           last_pair;

    always_comb begin
        a_mag     = i_a[EB-1] ? (~i_a + 1'b1) : i_a;
        b_mag     = i_b[EB-1] ? (~i_b + 1'b1) : i_b;
        rnd       = r_mag + (r_neg ? AW2'(16'hFFFF) : AW2'(0));
        shq       = rnd >> 16;
        ovf       = |shq[AW2-1:EB-1];
        if (r_neg) begin
            fin_q = ovf ? EMIN : (~shq[EB-1:0] + 1'b1);
        end else begin
            fin_q = ovf ? EMAX : shq[EB-1:0];
        end
        last_pair = (r_ci == CIW'(NCH - 1)) && (r_cj == CIW'(NCH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_st <= S_ADD;
                end
                S_ADD: begin
                    r_st <= last_pair ? S_FIN : S_MUL;
                end
                S_FIN: begin
                    r_st <= S_IDLE;
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                if (i_start) begin
                    r_x   <= MW'(a_mag);
                    r_y   <= MW'(b_mag);
                    r_neg <= i_a[EB-1] ^ i_b[EB-1];
                    r_ci  <= '0;
                    r_cj  <= '0;
                    r_mag <= '0;
                end
            end
            S_MUL: begin
                r_pp <= r_x[r_ci*CW +: CW] * r_y[r_cj*CW +: CW];
                r_sh <= SHW'(r_ci) + SHW'(r_cj);
            end
            S_ADD: begin
                r_mag <= r_mag + (AW2'(r_pp) << (r_sh * CW));
                if (r_cj == CIW'(NCH - 1)) begin
                    r_cj <= '0;
                    r_ci <= r_ci + 1'b1;
                end else begin
                    r_cj <= r_cj + 1'b1;
                end
            end
            S_FIN: begin
                r_q <= fin_q;
            end
            default: begin
            end
        endcase
    end

    assign o_busy = (r_st != S_IDLE);
    assign o_q    = r_q;

endmodule

`default_nettype wire

// ===== src/matrix_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// Matrix arithmetic unit
// Loads matrices A and B element by element and, on a compute transfer,
// emits the sum, difference, product or scaled A in Q16.16, column by column.
// ----------------------------------------------------------------------------
// A compute transfer is run by a microcoded sequencer and the block takes
// no input transfer until its last result has entered the output register.
// An add or subtract result is read from both element stores and combined;
// scale and product results use the shared iterative multiplier, which
// splits each operand into N = ceil(ELEM_BITS/32) chunks of at most 32
// bits, and a product result accumulates one multiplier result per column
// of A. The element stores read one entry per cycle each, so one product
// term starts at a time. A stalled output holds the sequencer. Bad
// dimensions give a single error item instead.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_arithmetic_unit_top #(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire mau_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output mau_pkg::t_out_item      o_out_item,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    import mau_pkg::*;

    localparam int EB      = ELEM_BITS;
    localparam int DIM_LIM = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam int DEPTH   = DIM_LIM * DIM_LIM;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic signed [EB-1:0] EMAX = {1'b0, {(EB-1){1'b1}}};
    localparam logic signed [EB-1:0] EMIN = {1'b1, {(EB-1){1'b0}}};

    function automatic logic [AW-1:0] f_addr(input logic [CNT_W-1:0] x,
                                             input logic [CNT_W-1:0] y);
        return AW'(32'(x) * DIM_LIM + 32'(y));
    endfunction

    function automatic logic signed [EB-1:0] f_sat_add(input logic signed [EB-1:0] a,
                                                       input logic signed [EB-1:0] b);
        logic [EB:0] s;
        s = {a[EB-1], a} + {b[EB-1], b};
        if (s[EB] != s[EB-1]) begin
            return s[EB] ? EMIN : EMAX;
        end
        return s[EB-1:0];
    endfunction

    function automatic logic signed [EB-1:0] f_sat_sub(input logic signed [EB-1:0] a,
                                                       input logic signed [EB-1:0] b);
        logic [EB:0] s;
        s = {a[EB-1], a} - {b[EB-1], b};
        if (s[EB] != s[EB-1]) begin
            return s[EB] ? EMIN : EMAX;
        end
        return s[EB-1:0];
    endfunction

    function automatic logic f_dim_ok(input logic [DIM_W-1:0] d);
        return (d != '0) && (d <= DIM_W'(DIM_LIM));
    endfunction

    // Configuration registers
    logic [1:0]         r_op_mode;
    logic [DIM_W-1:0]   r_a_cols;
    logic [DIM_W-1:0]   r_a_rows;
    logic [DIM_W-1:0]   r_b_cols;
    logic [DIM_W-1:0]   r_b_rows;
    logic signed [31:0] r_scale;

    // Sequencer and datapath
    logic [STEP_W-1:0]    r_step;
    logic [STEP_W-1:0]    n_step;
    logic [CNT_W-1:0]     r_x;
    logic [CNT_W-1:0]     r_y;
    logic [CNT_W-1:0]     r_i;
    logic signed [EB-1:0] r_acc;
    logic                 r_a_rv;
    logic                 r_b_rv;
    logic                 r_a_vld [DEPTH];
    logic                 r_b_vld [DEPTH];
    logic                 r_out_valid;
    t_out_item            r_out_item;

    t_uword               uw;
    logic                 go;
    logic                 taken;
    logic                 in_acc;
    logic                 out_free;
    logic                 dims_ok;
    logic                 wr_ok;
    logic [DIM_W-1:0]     oc;
    logic                 x_last;
    logic                 y_last;
    logic                 i_last;
    logic                 a_we;
    logic                 b_we;
    logic                 rd_en;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        a_raddr;
    logic [AW-1:0]        b_raddr;
    logic [EB-1:0]        a_rdata;
    logic [EB-1:0]        b_rdata;
    logic signed [EB-1:0] a_val;
    logic signed [EB-1:0] b_val;
    logic signed [EB-1:0] val_e;
    logic signed [EB-1:0] sf_e;
    logic signed [EB-1:0] mul_b;
    logic signed [EB-1:0] mul_q;
    logic                 mul_busy;
    logic                 mul_start;
    logic signed [EB-1:0] elem_res;
    logic                 cfg_wr;

    generate
        if (EB >= 32) begin : g_wide
            assign val_e = EB'(i_in_item.value);
            assign sf_e  = EB'(r_scale);
        end else begin : g_narrow
            assign val_e = (&i_in_item.value[31:EB-1] || ~|i_in_item.value[31:EB-1])
                         ? i_in_item.value[EB-1:0]
                         : (i_in_item.value[31] ? EMIN : EMAX);
            assign sf_e  = (&r_scale[31:EB-1] || ~|r_scale[31:EB-1])
                         ? r_scale[EB-1:0]
                         : (r_scale[31] ? EMIN : EMAX);
        end
    endgenerate

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode <= MODE_MUL;
            r_a_cols  <= DIM_W'(1);
            r_a_rows  <= DIM_W'(1);
            r_b_cols  <= DIM_W'(1);
            r_b_rows  <= DIM_W'(1);
            r_scale   <= 32'sd65536;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_OP_MODE: r_op_mode <= pwdata[1:0];
                REG_A_COLS:  r_a_cols  <= pwdata[DIM_W-1:0];
                REG_A_ROWS:  r_a_rows  <= pwdata[DIM_W-1:0];
                REG_B_COLS:  r_b_cols  <= pwdata[DIM_W-1:0];
                REG_B_ROWS:  r_b_rows  <= pwdata[DIM_W-1:0];
                REG_SCALE:   r_scale   <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_OP_MODE: prdata = 32'(r_op_mode);
            REG_A_COLS:  prdata = 32'(r_a_cols);
            REG_A_ROWS:  prdata = 32'(r_a_rows);
            REG_B_COLS:  prdata = 32'(r_b_cols);
            REG_B_ROWS:  prdata = 32'(r_b_rows);
            REG_SCALE:   prdata = r_scale;
            default:     prdata = '0;
        endcase
    end

    // Sequencer control
    always_comb begin
        uw       = uc_rom(r_step);
        in_acc   = i_in_valid && (r_step == ST_IDLE);
        out_free = !r_out_valid || !i_out_stall;

        dims_ok = f_dim_ok(r_a_cols) && f_dim_ok(r_a_rows);
        case (r_op_mode)
            MODE_ADD, MODE_SUB: begin
                dims_ok = dims_ok && (r_a_cols == r_b_cols) && (r_a_rows == r_b_rows);
            end
            MODE_MUL: begin
                dims_ok = dims_ok && f_dim_ok(r_b_cols) && (r_a_cols == r_b_rows);
            end
            default: begin
            end
        endcase

        oc     = (r_op_mode == MODE_MUL) ? r_b_cols : r_a_cols;
        x_last = (DIM_W'(r_x) + 1'b1) == oc;
        y_last = (DIM_W'(r_y) + 1'b1) == r_a_rows;
        i_last = (DIM_W'(r_i) + 1'b1) == r_a_cols;

        case (uw.wt)
            WT_NONE: go = 1'b1;
            WT_MUL:  go = !mul_busy;
            WT_OUT:  go = out_free;
            default: go = 1'b0;
        endcase

        case (uw.jmp)
            J_NEXT:  taken = 1'b0;
            J_ALW:   taken = 1'b1;
            J_NOGO:  taken = !(in_acc && (i_in_item.opcode == OPC_COMPUTE));
            J_ERR:   taken = !dims_ok;
            J_MUL:   taken = (r_op_mode == MODE_MUL);
            J_IMORE: taken = !i_last;
            J_YMORE: taken = !y_last;
            J_XMORE: taken = !x_last;
            default: taken = 1'b0;
        endcase

        if (!go) begin
            n_step = r_step;
        end else if (taken) begin
            n_step = uw.target;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            if (uw.clr_cnt) begin
                r_x <= '0;
                r_y <= '0;
                r_i <= '0;
            end else if (taken) begin
                case (uw.jmp)
                    J_IMORE: begin
                        r_i <= r_i + 1'b1;
                    end
                    J_YMORE: begin
                        r_y <= r_y + 1'b1;
                        r_i <= '0;
                    end
                    J_XMORE: begin
                        r_x <= r_x + 1'b1;
                        r_y <= '0;
                        r_i <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Element stores
    assign wr_ok = ({1'b0, i_in_item.col} < DIM_W'(DIM_LIM))
                && ({1'b0, i_in_item.row} < DIM_W'(DIM_LIM));
    assign a_we  = in_acc && (i_in_item.opcode == OPC_WRITE_A) && wr_ok;
    assign b_we  = in_acc && (i_in_item.opcode == OPC_WRITE_B) && wr_ok;
    assign waddr = f_addr(i_in_item.col, i_in_item.row);
    assign rd_en = go && (uw.rd != RD_NONE);

    always_comb begin
        if (uw.rd == RD_MAC) begin
            a_raddr = f_addr(r_i, r_y);
            b_raddr = f_addr(r_x, r_i);
        end else begin
            a_raddr = f_addr(r_x, r_y);
            b_raddr = f_addr(r_x, r_y);
        end
    end

    mau_ram #(.WIDTH(EB), .DEPTH(DEPTH)) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (waddr),
        .i_wdata (val_e),
        .i_re    (rd_en),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mau_ram #(.WIDTH(EB), .DEPTH(DEPTH)) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (waddr),
        .i_wdata (val_e),
        .i_re    (rd_en),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_a_vld[k] <= 1'b0;
                r_b_vld[k] <= 1'b0;
            end
        end else begin
            if (a_we) begin
                r_a_vld[waddr] <= 1'b1;
            end
            if (b_we) begin
                r_b_vld[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rv <= 1'b0;
            r_b_rv <= 1'b0;
        end else if (rd_en) begin
            r_a_rv <= r_a_vld[a_raddr];
            r_b_rv <= r_b_vld[b_raddr];
        end
    end

    assign a_val = r_a_rv ? signed'(a_rdata) : '0;
    assign b_val = r_b_rv ? signed'(b_rdata) : '0;

    // Multiplier and accumulator
    assign mul_b     = (r_op_mode == MODE_SCALE) ? sf_e : b_val;
    assign mul_start = go && uw.mstart
                    && ((r_op_mode == MODE_MUL) || (r_op_mode == MODE_SCALE));

    mau_qmul #(.EB(EB)) u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (a_val),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_q     (mul_q)
    );

    always_comb begin
        case (r_op_mode)
            MODE_ADD:   elem_res = f_sat_add(a_val, b_val);
            MODE_SUB:   elem_res = f_sat_sub(a_val, b_val);
            MODE_SCALE: elem_res = mul_q;
            default:    elem_res = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            case (uw.alu)
                ALU_ELEM: r_acc <= elem_res;
                ALU_MAC:  r_acc <= f_sat_add(r_acc, mul_q);
                ALU_CLR:  r_acc <= '0;
                default: begin
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && (uw.emit != EM_NONE)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            case (uw.emit)
                EM_DATA: begin
                    r_out_item.out_col   <= r_x;
                    r_out_item.out_row   <= r_y;
                    r_out_item.out_value <= 32'(r_acc);
                    r_out_item.last      <= x_last && y_last;
                    r_out_item.error     <= 1'b0;
                end
                EM_ERR: begin
                    r_out_item.out_col   <= '0;
                    r_out_item.out_row   <= '0;
                    r_out_item.out_value <= '0;
                    r_out_item.last      <= 1'b1;
                    r_out_item.error     <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall  = (r_step != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== tb/tb_matrix_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the matrix arithmetic unit
// Loads elements into the A and B stores, runs add, subtract, multiply and
// scale computations under many register settings, and checks every result
// element against a Q16.16 predictor kept inside this testbench. Both
// channels idle at random. The register port writes only while the block
// is idle.
// ----------------------------------------------------------------------------

module tb_matrix_arithmetic_unit_top;
    import mau_pkg::*;

    localparam logic [1:0] OPC_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 64;
    localparam int         STALL_LIMIT   = 5000;
    localparam int         RANDOM_ITEMS  = 80;
    localparam longint     Q_MAX         = 64'sd2147483647;
    localparam longint     Q_MIN         = -64'sd2147483648;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [4:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state.
    logic signed [31:0] mat_a [0:63];
    logic signed [31:0] mat_b [0:63];
    logic [1:0]         cfg_mode;
    logic [3:0]         cfg_a_cols, cfg_a_rows, cfg_b_cols, cfg_b_rows;
    logic signed [31:0] cfg_scale;

    t_out_item pending_elems[$];
    bit        gaps_on = 1'b1;
    int        n_err = 0;
    int        n_items = 0;
    int        n_computes = 0;
    int        n_results = 0;
    int        n_reg_writes = 0;
    int        quiet_cycles = 0;

    matrix_arithmetic_unit_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > Q_MAX) begin
            return 32'sh7fff_ffff;
        end
        if (v < Q_MIN) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Exact product, shifted right by 16 with floor rounding, then saturated.
    function automatic logic signed [31:0] q16_mul(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp32(p >>> 16);
    endfunction

    function automatic bit dim_ok(input logic [3:0] d);
        return d >= 4'd1 && d <= 4'd8;
    endfunction

    function automatic void predict_result_matrix();
        t_out_item          r;
        bit                 ok;
        int                 ncols;
        int                 nrows;
        logic signed [31:0] v;
        ok = dim_ok(cfg_a_cols) && dim_ok(cfg_a_rows);
        if (cfg_mode == MODE_ADD || cfg_mode == MODE_SUB) begin
            ok = ok && cfg_a_cols == cfg_b_cols && cfg_a_rows == cfg_b_rows;
        end else if (cfg_mode == MODE_MUL) begin
            ok = ok && dim_ok(cfg_b_cols) && cfg_a_cols == cfg_b_rows;
        end
        if (!ok) begin
            r = '0;
            r.last = 1'b1;
            r.error = 1'b1;
            pending_elems.push_back(r);
            return;
        end
        ncols = (cfg_mode == MODE_MUL) ? int'(cfg_b_cols) : int'(cfg_a_cols);
        nrows = int'(cfg_a_rows);
        for (int x = 0; x < ncols; x++) begin
            for (int y = 0; y < nrows; y++) begin
                case (cfg_mode)
                    MODE_ADD: begin
                        v = clamp32(longint'(mat_a[x*8+y]) + longint'(mat_b[x*8+y]));
                    end
                    MODE_SUB: begin
                        v = clamp32(longint'(mat_a[x*8+y]) - longint'(mat_b[x*8+y]));
                    end
                    MODE_MUL: begin
                        v = '0;
                        for (int i = 0; i < int'(cfg_a_cols); i++) begin
                            v = clamp32(longint'(v) +
                                        longint'(q16_mul(mat_a[i*8+y], mat_b[x*8+i])));
                        end
                    end
                    default: begin
                        v = q16_mul(mat_a[x*8+y], cfg_scale);
                    end
                endcase
                r.out_col   = 3'(x);
                r.out_row   = 3'(y);
                r.out_value = v;
                r.last      = (x == ncols - 1) && (y == nrows - 1);
                r.error     = 1'b0;
                pending_elems.push_back(r);
            end
        end
    endfunction

    function automatic void apply_transfer(input t_in_item it);
        case (it.opcode)
            OPC_WRITE_A: mat_a[{it.col, it.row}] = it.value;
            OPC_WRITE_B: mat_b[{it.col, it.row}] = it.value;
            OPC_COMPUTE: begin
                n_computes++;
                predict_result_matrix();
            end
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        int s;
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3, 4: begin
                s = int'($urandom_range(0, 393216)) - 196608;
                return s;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        n_err++;
    endtask

    task automatic send_elem(input logic [1:0] opc, input int c, input int r,
                             input logic [31:0] v);
        t_in_item it;
        it.opcode = opc;
        it.col    = 3'(c);
        it.row    = 3'(r);
        it.value  = v;
        while (gaps_on && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        apply_transfer(it);
        if (opc != OPC_UNUSED) begin
            n_items++;
        end
    endtask

    // Holds the sender until every predicted element has arrived and the
    // sequencer has had time to return to idle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_elems.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_OP_MODE: cfg_mode   = data[1:0];
            REG_A_COLS:  cfg_a_cols = data[3:0];
            REG_A_ROWS:  cfg_a_rows = data[3:0];
            REG_B_COLS:  cfg_b_cols = data[3:0];
            REG_B_ROWS:  cfg_b_rows = data[3:0];
            REG_SCALE:   cfg_scale  = data;
            default: ;
        endcase
        n_reg_writes++;
    endtask

    task automatic set_shape(input logic [1:0] mode, input int ac, input int ar,
                             input int bc, input int br);
        write_reg(REG_OP_MODE, 32'(mode));
        write_reg(REG_A_COLS, 32'(ac));
        write_reg(REG_A_ROWS, 32'(ar));
        write_reg(REG_B_COLS, 32'(bc));
        write_reg(REG_B_ROWS, 32'(br));
    endtask

    task automatic test_reset_defaults();
        send_elem(OPC_COMPUTE, 0, 0, 32'h0);
        send_elem(OPC_WRITE_A, 0, 0, 32'h7fff_ffff);
        send_elem(OPC_WRITE_B, 0, 0, 32'h7fff_ffff);
        send_elem(OPC_UNUSED, 5, 2, $urandom);
        send_elem(OPC_COMPUTE, 0, 0, 32'h0);
    endtask

    task automatic test_add_sub();
        wait_idle();
        set_shape(MODE_ADD, 2, 2, 2, 2);
        send_elem(OPC_WRITE_A, 0, 0, 32'h8000_0000);
        send_elem(OPC_WRITE_B, 0, 0, 32'h8000_0000);
        send_elem(OPC_WRITE_A, 1, 0, 32'h7fff_ffff);
        send_elem(OPC_WRITE_B, 1, 0, 32'h0000_0001);
        send_elem(OPC_WRITE_A, 0, 1, 32'h8000_0000);
        send_elem(OPC_WRITE_B, 0, 1, 32'h7fff_ffff);
        send_elem(OPC_WRITE_A, 1, 1, 32'h7fff_ffff);
        send_elem(OPC_WRITE_B, 1, 1, 32'h8000_0000);
        send_elem(OPC_COMPUTE, 0, 0, 32'h0);
        wait_idle();
        write_reg(REG_OP_MODE, 32'(MODE_SUB));
        send_elem(OPC_COMPUTE, 7, 7, 32'hffff_ffff);
    endtask

    task automatic test_multiply_full();
        wait_idle();
        set_shape(MODE_MUL, 8, 8, 8, 8);
        send_elem(OPC_WRITE_A, 7, 7, 32'h8000_0000);
        send_elem(OPC_WRITE_B, 7, 7, 32'h8000_0000);
        send_elem(OPC_WRITE_A, 7, 3, 32'hffff_ffff);
        send_elem(OPC_WRITE_B, 2, 7, 32'h0000_0001);
        send_elem(OPC_COMPUTE, 0, 0, 32'h0);
    endtask

    task automatic test_scale();
        wait_idle();
        set_shape(MODE_SCALE, 2, 2, 5, 1);
        write_reg(REG_SCALE, 32'h8000_0000);
        send_elem(OPC_COMPUTE, 0, 0, 32'h0);
        wait_idle();
        write_reg(REG_SCALE, 32'h7fff_ffff);
        send_elem(OPC_COMPUTE, 0, 0, 32'h0);
    endtask

    task automatic test_size_errors();
        wait_idle();
        set_shape(MODE_ADD, 3, 2, 2, 2);
        send_elem(OPC_COMPUTE, 0, 0, 32'h0);
        wait_idle();
        set_shape(MODE_MUL, 3, 2, 2, 2);
        send_elem(OPC_COMPUTE, 0, 0, 32'h0);
        wait_idle();
        set_shape(MODE_SCALE, 2, 0, 2, 2);
        send_elem(OPC_COMPUTE, 0, 0, 32'h0);
        wait_idle();
        set_shape(MODE_MUL, 9, 2, 15, 9);
        send_elem(OPC_COMPUTE, 0, 0, 32'h0);
    endtask

    task automatic test_random_sequences();
        int         target;
        int         phase;
        int         maxd;
        int         ac, ar, bc, br;
        int         acl, arl, bcl, brl;
        int         nloads;
        logic [1:0] mode;
        target = n_items + RANDOM_ITEMS;
        phase = 0;
        while (n_items < target) begin
            // The first few sequences run with both sides never idling.
            gaps_on = (phase >= 4);
            wait_idle();
            mode = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 12) begin
                ac = $urandom_range(0, 15);
                ar = $urandom_range(0, 15);
                bc = $urandom_range(0, 15);
                br = $urandom_range(0, 15);
            end else begin
                maxd = ($urandom_range(0, 9) == 0) ? 8 : 4;
                ac = $urandom_range(1, maxd);
                ar = $urandom_range(1, maxd);
                bc = $urandom_range(1, maxd);
                br = $urandom_range(1, maxd);
                if (mode == MODE_ADD || mode == MODE_SUB) begin
                    bc = ac;
                    br = ar;
                end else if (mode == MODE_MUL) begin
                    br = ac;
                end
            end
            write_reg(REG_OP_MODE, {30'($urandom), mode});
            write_reg(REG_A_COLS, {28'($urandom), 4'(ac)});
            write_reg(REG_A_ROWS, {28'($urandom), 4'(ar)});
            write_reg(REG_B_COLS, {28'($urandom), 4'(bc)});
            write_reg(REG_B_ROWS, {28'($urandom), 4'(br)});
            write_reg(REG_SCALE, rand_value());
            acl = (ac < 1) ? 1 : ((ac > 8) ? 8 : ac);
            arl = (ar < 1) ? 1 : ((ar > 8) ? 8 : ar);
            bcl = (bc < 1) ? 1 : ((bc > 8) ? 8 : bc);
            brl = (br < 1) ? 1 : ((br > 8) ? 8 : br);
            repeat ($urandom_range(1, 2)) begin
                nloads = $urandom_range(2, 10);
                for (int k = 0; k < nloads; k++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        send_elem(OPC_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                                  $urandom);
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        send_elem($urandom_range(0, 1) ? OPC_WRITE_A : OPC_WRITE_B,
                                  $urandom_range(0, 7), $urandom_range(0, 7),
                                  rand_value());
                    end else if ($urandom_range(0, 1)) begin
                        send_elem(OPC_WRITE_A, $urandom_range(0, acl - 1),
                                  $urandom_range(0, arl - 1), rand_value());
                    end else begin
                        send_elem(OPC_WRITE_B, $urandom_range(0, bcl - 1),
                                  $urandom_range(0, brl - 1), rand_value());
                    end
                end
                send_elem(OPC_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                          $urandom);
            end
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(0, 99) < 7);
    end

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_item;
            n_results++;
            if (pending_elems.size() == 0) begin
                report_mismatch($sformatf("result with none predicted: col %0d row %0d value %h",
                                          got.out_col, got.out_row, got.out_value));
            end else begin
                want = pending_elems.pop_front();
                if (got.out_col !== want.out_col) begin
                    report_mismatch($sformatf("out_col got %0d want %0d",
                                              got.out_col, want.out_col));
                end
                if (got.out_row !== want.out_row) begin
                    report_mismatch($sformatf("out_row got %0d want %0d",
                                              got.out_row, want.out_row));
                end
                if (got.out_value !== want.out_value) begin
                    report_mismatch($sformatf("out_value at (%0d,%0d) got %h want %h",
                                              want.out_col, want.out_row,
                                              got.out_value, want.out_value));
                end
                if (got.last !== want.last) begin
                    report_mismatch($sformatf("last at (%0d,%0d) got %b want %b",
                                              want.out_col, want.out_row, got.last, want.last));
                end
                if (got.error !== want.error) begin
                    report_mismatch($sformatf("error got %b want %b", got.error, want.error));
                end
            end
        end
    end

    // Ends the run when no transfer of any kind has happened for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("** matrix_arithmetic_unit_top: FAILED **");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 64; i++) begin
            mat_a[i] = '0;
            mat_b[i] = '0;
        end
        cfg_mode   = MODE_MUL;
        cfg_a_cols = 4'd1;
        cfg_a_rows = 4'd1;
        cfg_b_cols = 4'd1;
        cfg_b_rows = 4'd1;
        cfg_scale  = 32'sd65536;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_add_sub();
        test_multiply_full();
        test_scale();
        test_size_errors();
        test_random_sequences();
        wait_idle();
        if (pending_elems.size() != 0) begin
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      pending_elems.size()));
        end

        $display("Covered %0d input transfers, %0d computes and %0d register writes;",
                 n_items, n_computes, n_reg_writes);
        $display("checked %0d result elements over all four operations and size errors.",
                 n_results);
        if (n_err == 0) begin
            $display("** matrix_arithmetic_unit_top: PASSED **");
        end else begin
            $display("** matrix_arithmetic_unit_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== matrix_arithmetic_unit_top.f =====
src/mau_pkg.sv
src/mau_ram.sv
src/mau_qmul.sv
src/matrix_arithmetic_unit_top.sv
tb/tb_matrix_arithmetic_unit_top.sv
